### rtl/core/binary_heap_priority_queue_macros.svh
// ---------------------------------------------------------------------------
// Heap assertion macros
// Same-cycle and next-cycle implication checks for the heap block.
// ---------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define BHPQ_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("bhpq");
// Assert that a condition implies a consequence on the next cycle.
`define BHPQ_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("bhpq");
`endif

### rtl/core/bhpq_pkg.sv
// ---------------------------------------------------------------------------
// Heap package
// Types and codes shared by the heap priority queue.
// ---------------------------------------------------------------------------
`default_nettype none
package bhpq_pkg;
   localparam logic [1:0] FUNC_INSERT  = 2'd0;
   localparam logic [1:0] FUNC_EXTRACT = 2'd1;
   localparam logic [1:0] FUNC_REMOVE  = 2'd2;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   localparam int KEY_W = 32;
   localparam int OCC_W = 7;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_LAST, S_LD_LAST, S_SRCH, S_TAIL,
      S_UP_RD, S_UP_CMP, S_DN_SEED, S_DN_LOAD, S_DN_L, S_DN_R, S_DN_CMP, S_RESP
   } state_type;
endpackage
`default_nettype wire

### rtl/core/bhpq_if.sv
// ---------------------------------------------------------------------------
// Heap channel interfaces
// Valid/ready channels for requests, responses and the control register.
// ---------------------------------------------------------------------------
`default_nettype none
interface bhpq_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [31:0] key_value;
   modport source (output valid, func, key_value, input ready);
   modport sink   (input valid, func, key_value, output ready);
endinterface

interface bhpq_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] top_value;
   logic [6:0]         occupancy;
   modport source (output valid, status, top_value, occupancy, input ready);
   modport sink   (input valid, status, top_value, occupancy, output ready);
endinterface

interface bhpq_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/core/bhpq_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module bhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/core/binary_heap_priority_queue.sv
// ---------------------------------------------------------------------------
// Binary heap priority queue
// Signed 32-bit keys in a RAM-held binary heap, min or max ordering.
// ---------------------------------------------------------------------------
// One word in, one word out. Insert appends and sifts up, extract returns the
// root and sifts the last key down from the root, remove searches the store
// linearly for the first match, moves the last key into its slot, sifts it up
// and then sifts whatever sits in that slot down. A small sequencer drives one
// shared comparator and a RAM with one write and one registered read port.
// The moving key is held in a register and written only where it stops.
// A waiting response word sits in its own register, so the next word
// may be taken while it waits, but a finished item cannot hand over until the
// previous word has gone. order_mode is written through the csr channel while
// idle and is not applied to keys already held. The store needs no clearing
// after reset: only slots below the count are ever read.
// ---------------------------------------------------------------------------
`default_nettype none
`include "binary_heap_priority_queue_macros.svh"
module binary_heap_priority_queue
   import bhpq_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input wire logic clock,
   input wire logic reset,
   bhpq_req_if.sink   req,
   bhpq_rsp_if.source rsp,
   bhpq_csr_if.sink   csr
);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   state_type state_ff, state_in;
   logic             mode_ff, mode_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [1:0]       func_ff, func_in;
   logic [KEY_W-1:0] key_ff, key_in;         // moving key
   logic [AW-1:0]    idx_ff, idx_in;         // current slot
   logic [AW-1:0]    hole_ff, hole_in;       // slot a remove sifts down from
   logic [AW-1:0]    cix_ff, cix_in;         // best slot so far
   logic [KEY_W-1:0] bkey_ff, bkey_in;       // best key so far
   logic [1:0]       st_ff, st_in;
   logic [KEY_W-1:0] top_ff, top_in;
   logic             rvld_ff, rvld_in;
   logic [1:0]       rsp_st_ff, rsp_st_in;
   logic [KEY_W-1:0] rsp_top_ff, rsp_top_in;
   logic [OCC_W-1:0] rsp_occ_ff, rsp_occ_in;

   logic             we;
   logic [AW-1:0]    wa, ra;
   logic [KEY_W-1:0] wd, rd;

   logic [KEY_W-1:0] cmp_a, cmp_b;
   logic             cmp_above;
   logic [XW-1:0]    lidx, ridx, cnt_x;
   logic [AW-1:0]    pidx;
   logic [CW-1:0]    idx_c;

   bhpq_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ram (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd)
   );

   // Strictly-above compare: the one shared comparator.
   function automatic logic above(input logic m, input logic [KEY_W-1:0] a,
                                  input logic [KEY_W-1:0] b);
      return m ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
   endfunction

   assign cmp_above = above(mode_ff, cmp_a, cmp_b);

   // Child and parent slots of the current slot.
   assign lidx  = {1'b0, idx_ff, 1'b1};
   assign ridx  = {1'b0, idx_ff, 1'b0} + XW'(2);
   assign cnt_x = XW'(cnt_ff);
   assign pidx  = (idx_ff - AW'(1)) >> 1;
   assign idx_c = CW'(idx_ff);

   assign req.ready  = (state_ff == S_IDLE);
   assign csr.ready  = (state_ff == S_IDLE);
   assign rsp.valid  = rvld_ff;
   assign rsp.status = rsp_st_ff;
   assign rsp.top_value = rsp_top_ff;
   assign rsp.occupancy = rsp_occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= 1'b0;
         cnt_ff   <= '0;
         rvld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         cnt_ff   <= cnt_in;
         rvld_ff  <= rvld_in;
      end
      func_ff    <= func_in;
      key_ff     <= key_in;
      idx_ff     <= idx_in;
      hole_ff    <= hole_in;
      cix_ff     <= cix_in;
      bkey_ff    <= bkey_in;
      st_ff      <= st_in;
      top_ff     <= top_in;
      rsp_st_ff  <= rsp_st_in;
      rsp_top_ff <= rsp_top_in;
      rsp_occ_ff <= rsp_occ_in;
   end

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      cnt_in     = cnt_ff;
      rvld_in    = rvld_ff;
      func_in    = func_ff;
      key_in     = key_ff;
      idx_in     = idx_ff;
      hole_in    = hole_ff;
      cix_in     = cix_ff;
      bkey_in    = bkey_ff;
      st_in      = st_ff;
      top_in     = top_ff;
      rsp_st_in  = rsp_st_ff;
      rsp_top_in = rsp_top_ff;
      rsp_occ_in = rsp_occ_ff;
      we = 1'b0;
      wa = idx_ff;
      wd = key_ff;
      ra = idx_ff;
      cmp_a = key_ff;
      cmp_b = rd;
      if (rsp.ready) begin
         rvld_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (csr.valid) begin
               mode_in = csr.data;
            end
            if (req.valid) begin
               func_in = req.func;
               key_in  = req.key_value;
               st_in   = ST_OK;
               top_in  = '0;
               idx_in  = '0;
               case (req.func)
                  FUNC_INSERT: begin
                     if (cnt_ff >= CAP_C) begin
                        st_in = ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        // Open a hole at the tail, then climb.
                        idx_in = AW'(cnt_ff);
                        cnt_in = cnt_ff + CW'(1);
                        state_in = S_UP_RD;
                     end
                  end
                  FUNC_EXTRACT: begin
                     if (cnt_ff == '0) begin
                        st_in = ST_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        ra = '0;
                        state_in = S_RD_LAST;
                     end
                  end
                  FUNC_REMOVE: begin
                     if (cnt_ff == '0) begin
                        st_in = ST_NOTFOUND;
                        state_in = S_RESP;
                     end else begin
                        ra = '0;
                        state_in = S_SRCH;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_RD_LAST: begin
            // Root data arrives; fetch the tail.
            top_in = rd;
            cnt_in = cnt_ff - CW'(1);
            ra = AW'(cnt_ff - CW'(1));
            state_in = S_LD_LAST;
         end
         S_LD_LAST: begin
            // Tail key becomes the key sifted down from the root.
            key_in = rd;
            idx_in = '0;
            state_in = (cnt_ff == '0) ? S_RESP : S_DN_L;
         end
         S_SRCH: begin
            // rd holds slot idx; the next slot is addressed every cycle.
            if (rd == key_ff) begin
               cnt_in = cnt_ff - CW'(1);
               if (idx_c == cnt_ff - CW'(1)) begin
                  state_in = S_RESP;
               end else begin
                  ra = AW'(cnt_ff - CW'(1));
                  hole_in = idx_ff;
                  state_in = S_TAIL;
               end
            end else if (idx_c + CW'(1) >= cnt_ff) begin
               st_in = ST_NOTFOUND;
               state_in = S_RESP;
            end else begin
               idx_in = idx_ff + AW'(1);
               ra = idx_ff + AW'(1);
            end
         end
         S_TAIL: begin
            // Tail key fills the hole; sift it up from there.
            key_in = rd;
            state_in = S_UP_RD;
         end
         S_UP_RD: begin
            if (idx_ff == '0) begin
               // Park the key at the root.
               we = 1'b1;
               state_in = (func_ff == FUNC_REMOVE) ? S_DN_SEED : S_RESP;
            end else begin
               ra = pidx;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            cmp_a = key_ff;
            cmp_b = rd;
            we = 1'b1;
            if (cmp_above) begin
               // Parent drops into this slot, key climbs.
               wd = rd;
               idx_in = pidx;
               state_in = S_UP_RD;
            end else begin
               state_in = (func_ff == FUNC_REMOVE) ? S_DN_SEED : S_RESP;
            end
         end
         S_DN_SEED: begin
            // Re-read the removal slot; it may now hold a dropped parent.
            idx_in = hole_ff;
            ra = hole_ff;
            state_in = S_DN_LOAD;
         end
         S_DN_LOAD: begin
            key_in = rd;
            state_in = S_DN_L;
         end
         S_DN_L: begin
            if (lidx >= cnt_x) begin
               // Leaf: park the key here.
               we = 1'b1;
               state_in = S_RESP;
            end else begin
               ra = AW'(lidx);
               state_in = S_DN_R;
            end
         end
         S_DN_R: begin
            // rd holds the left child.
            cmp_a = rd;
            cmp_b = key_ff;
            if (ridx < cnt_x) begin
               bkey_in = cmp_above ? rd : key_ff;
               cix_in  = cmp_above ? AW'(lidx) : idx_ff;
               ra = AW'(ridx);
               state_in = S_DN_CMP;
            end else begin
               we = 1'b1;
               if (cmp_above) begin
                  wd = rd;
                  idx_in = AW'(lidx);
                  state_in = S_DN_L;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_DN_CMP: begin
            // rd holds the right child; it wins only when strictly above.
            cmp_a = rd;
            cmp_b = bkey_ff;
            we = 1'b1;
            if (cmp_above) begin
               wd = rd;
               idx_in = AW'(ridx);
               state_in = S_DN_L;
            end else if (cix_ff != idx_ff) begin
               wd = bkey_ff;
               idx_in = cix_ff;
               state_in = S_DN_L;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            // Hand over once the output register is free.
            if (!rvld_ff || rsp.ready) begin
               rvld_in    = 1'b1;
               rsp_st_in  = st_ff;
               rsp_top_in = top_ff;
               rsp_occ_in = OCC_W'(cnt_ff);
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   `BHPQ_ASSERT_IMP(a_cnt_cap, clock, reset, 1'b1, cnt_ff <= CAP_C)
   `BHPQ_ASSERT_IMP(a_busy, clock, reset, state_ff != S_IDLE, !req.ready)
   `BHPQ_ASSERT_NXT(a_rsp, clock, reset, state_ff == S_RESP && state_in == S_IDLE,
                    rsp.valid)
   `BHPQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready,
                    rsp.valid && $stable(rsp.status) && $stable(rsp.top_value) && $stable(rsp.occupancy))
endmodule
`default_nettype wire
